// ===== rtl/core/srtc_pkg.sv =====
package srtc_pkg;

  localparam int unsigned PinW  = 4;
  localparam int unsigned DateW = 32;

  localparam logic [3:0] CmdMagic      = 4'h6;
  localparam logic [7:0] StatusRstVal  = 8'h40;
  localparam logic [DateW-1:0] DateLowRstVal  = 32'h030A_0224;
  localparam logic [DateW-1:0] DateHighRstVal = 32'h0030_0910;

  // byte counts of the data phase per command
  localparam logic [2:0] DateTimeBytes = 3'd7;
  localparam logic [2:0] TimeBytes     = 3'd3;
  localparam logic [2:0] StatusBytes   = 3'd1;

  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_CLK  = 2'd1,
    PHASE_XFER = 2'd2
  } link_phase_e;

  typedef enum logic [2:0] {
    CMD_RESET     = 3'd0,
    CMD_DATETIME  = 3'd2,
    CMD_FORCE_IRQ = 3'd3,
    CMD_STATUS    = 3'd4,
    CMD_TIME      = 3'd6
  } cmd_sel_e;

  typedef enum logic {
    CFG_DATE_LOW  = 1'b0,
    CFG_DATE_HIGH = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [PinW-1:0] pin_levels;
    logic [PinW-1:0] pin_directions;
  } item_t;

  typedef struct packed {
    logic [PinW-1:0] pins_out;
    logic            pins_updated;
  } result_t;

endpackage

// ===== rtl/core/serial_rtc_gpio_interface.sv =====
// flow: a transaction accepted into the input register is stepped into the result register
// once the output is free, and its result is then offered on the outputs
// throughput: one transaction per cycle while the output is not stalled; the core state loop sets it
// reset: link idle, shift and command state cleared, status byte 0x40,
// date words at their default values, both pipeline registers empty
module serial_rtc_gpio_interface (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [srtc_pkg::DateW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [srtc_pkg::PinW-1:0]    pin_levels_i,
  input  logic [srtc_pkg::PinW-1:0]    pin_directions_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [srtc_pkg::PinW-1:0]    pins_out_o,
  output logic                         pins_updated_o
);

  logic [srtc_pkg::DateW-1:0] date_low_q;
  logic [srtc_pkg::DateW-1:0] date_high_q;

  logic              in_valid_q;
  srtc_pkg::item_t   item_q;
  logic              out_valid_q;
  srtc_pkg::result_t res_q;
  srtc_pkg::result_t step_res;
  logic              out_free;
  logic              advance;
  srtc_pkg::cfg_reg_e cfg_sel;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign cfg_sel    = srtc_pkg::cfg_reg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      date_low_q  <= srtc_pkg::DateLowRstVal;
      date_high_q <= srtc_pkg::DateHighRstVal;
    end else if (cfg_we_i) begin
      case (cfg_sel)
        srtc_pkg::CFG_DATE_LOW:  date_low_q  <= cfg_data_i;
        srtc_pkg::CFG_DATE_HIGH: date_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q.pin_levels     <= pin_levels_i;
      item_q.pin_directions <= pin_directions_i;
    end
    if (advance) res_q <= step_res;
  end

  srtc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .item_i      (item_q),
    .date_low_i  (date_low_q),
    .date_high_i (date_high_q),
    .result_o    (step_res)
  );

  assign out_valid_o    = out_valid_q;
  assign pins_out_o     = res_q.pins_out;
  assign pins_updated_o = res_q.pins_updated;

endmodule

// ===== rtl/core/srtc_core.sv =====
module srtc_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  srtc_pkg::item_t                  item_i,
  input  logic [srtc_pkg::DateW-1:0]       date_low_i,
  input  logic [srtc_pkg::DateW-1:0]       date_high_i,
  output srtc_pkg::result_t                result_o
);

  srtc_pkg::link_phase_e phase_q, phase_d;
  logic [7:0] shift_q, shift_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] cmd_q, cmd_d;
  logic       active_q, active_d;
  logic [2:0] rem_q, rem_d;
  logic [7:0] status_q, status_d;

  logic [2*srtc_pkg::DateW-1:0] date_all;
  logic [2:0]                   date_idx;
  logic [7:0]                   out_byte;
  logic                         out_bit;
  srtc_pkg::cmd_sel_e           cur_sel;
  srtc_pkg::cmd_sel_e           new_sel;

  assign date_all = {date_high_i, date_low_i};
  assign date_idx = 3'd7 - rem_q;
  assign cur_sel  = srtc_pkg::cmd_sel_e'(cmd_q[6:4]);
  assign new_sel  = srtc_pkg::cmd_sel_e'(shift_q[6:4]);

  // bit the device sends on a read
  always_comb begin
    out_byte = 8'h00;
    case (cur_sel)
      srtc_pkg::CMD_DATETIME, srtc_pkg::CMD_TIME: out_byte = date_all[{date_idx, 3'b000} +: 8];
      srtc_pkg::CMD_STATUS: out_byte = status_q;
      default: out_byte = 8'h00;
    endcase
    out_bit = active_q & out_byte[bit_q];
  end

  always_comb begin
    logic [3:0] pins;
    logic [3:0] dirs;
    logic [3:0] drv;
    logic [2:0] rem_dec;
    logic [2:0] rem_new;
    pins     = item_i.pin_levels;
    dirs     = item_i.pin_directions;
    drv      = {1'b0, 1'b1, out_bit, 1'b1};
    rem_dec  = (rem_q != 3'd0) ? rem_q - 3'd1 : 3'd0;
    rem_new  = 3'd0;
    phase_d  = phase_q;
    shift_d  = shift_q;
    bit_d    = bit_q;
    cmd_d    = cmd_q;
    active_d = active_q;
    rem_d    = rem_q;
    status_d = status_q;
    result_o.pins_out     = pins;
    result_o.pins_updated = 1'b0;

    case (phase_q)
      srtc_pkg::PHASE_IDLE: begin
        if ({pins[2], pins[0]} == 2'b01) phase_d = srtc_pkg::PHASE_CLK;
      end
      srtc_pkg::PHASE_CLK: begin
        if ({pins[2], pins[0]} == 2'b11) begin
          phase_d = srtc_pkg::PHASE_XFER;
        end else if ({pins[2], pins[0]} != 2'b01) begin
          phase_d = srtc_pkg::PHASE_IDLE;
        end
      end
      srtc_pkg::PHASE_XFER: begin
        if (!pins[0]) begin
          shift_d[bit_q] = pins[1];
        end else if (pins[2]) begin
          bit_d = bit_q + 3'd1;
          if (cmd_q[7]) begin
            result_o.pins_out     = (pins & dirs) | (drv & ~dirs);
            result_o.pins_updated = 1'b1;
            if (bit_q == 3'd7) begin
              rem_d = rem_dec;
              if (rem_dec == 3'd0) begin
                active_d = 1'b0;
                cmd_d    = 8'h00;
              end
            end
          end else if (bit_q == 3'd7) begin
            shift_d = 8'h00;
            bit_d   = 3'd0;
            if (!active_q) begin
              if (shift_q[3:0] == srtc_pkg::CmdMagic) begin
                case (new_sel)
                  srtc_pkg::CMD_RESET: begin
                    status_d = 8'h00;
                    rem_new  = 3'd0;
                  end
                  srtc_pkg::CMD_DATETIME: rem_new = srtc_pkg::DateTimeBytes;
                  srtc_pkg::CMD_STATUS:   rem_new = srtc_pkg::StatusBytes;
                  srtc_pkg::CMD_TIME:     rem_new = srtc_pkg::TimeBytes;
                  default:                rem_new = 3'd0;
                endcase
                if (rem_new == 3'd0) begin
                  active_d = 1'b0;
                  cmd_d    = 8'h00;
                  rem_d    = 3'd0;
                end else begin
                  active_d = 1'b1;
                  cmd_d    = shift_q;
                  rem_d    = rem_new;
                end
              end
            end else begin
              if (cur_sel == srtc_pkg::CMD_STATUS) status_d = shift_q;
              rem_d = rem_dec;
              if (rem_dec == 3'd0) begin
                active_d = 1'b0;
                cmd_d    = 8'h00;
              end
            end
          end
        end else begin
          // select dropped with clock high: abort, keep status
          shift_d  = 8'h00;
          bit_d    = 3'd0;
          cmd_d    = 8'h00;
          active_d = 1'b0;
          rem_d    = 3'd0;
          phase_d  = srtc_pkg::PHASE_CLK;
          result_o.pins_out     = (pins & dirs) | (4'b0001 & ~dirs);
          result_o.pins_updated = 1'b1;
        end
      end
      default: phase_d = srtc_pkg::PHASE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= srtc_pkg::PHASE_IDLE;
      shift_q  <= 8'h00;
      bit_q    <= 3'd0;
      cmd_q    <= 8'h00;
      active_q <= 1'b0;
      rem_q    <= 3'd0;
      status_q <= srtc_pkg::StatusRstVal;
    end else if (en_i) begin
      phase_q  <= phase_d;
      shift_q  <= shift_d;
      bit_q    <= bit_d;
      cmd_q    <= cmd_d;
      active_q <= active_d;
      rem_q    <= rem_d;
      status_q <= status_d;
    end
  end

  a_active_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> rem_q != 3'd0)
    else $error("active command with no bytes left");

  a_idle_cmd_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (cmd_q == 8'h00 && rem_q == 3'd0))
    else $error("stale command state without active command");

  a_link_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != srtc_pkg::PHASE_XFER |-> (bit_q == 3'd0 && shift_q == 8'h00 && !active_q))
    else $error("shift state not clear outside transfer");

  a_update_in_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && result_o.pins_updated) |-> phase_q == srtc_pkg::PHASE_XFER)
    else $error("pins rewritten outside transfer");

endmodule

// ===== dv/serial_rtc_gpio_interface_tb.sv =====
module serial_rtc_gpio_interface_tb;
  import srtc_pkg::*;

  localparam int ResultLatency = 2;
  localparam int ItemGoal      = 1400;
  localparam int RandomItems   = 340;
  localparam int CmdReadIdx    = 7;
  // low nibble is not the command magic, so the byte is dropped
  localparam logic [7:0] BadMagicCmd = 8'h07;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_index_i = 1'b0;
  logic [DateW-1:0]    cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [PinW-1:0]     pin_levels_i = '0;
  logic [PinW-1:0]     pin_directions_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [PinW-1:0]     pins_out_o;
  logic                pins_updated_o;

  serial_rtc_gpio_interface dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pin_levels_i    (pin_levels_i),
    .pin_directions_i(pin_directions_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pins_out_o      (pins_out_o),
    .pins_updated_o  (pins_updated_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // device state as the CPU would see it
  link_phase_e   rtc_phase;
  logic [7:0]    rtc_shift;
  logic [2:0]    rtc_bit;
  logic [7:0]    rtc_cmd;
  logic          rtc_cmd_on;
  logic [2:0]    rtc_left;
  logic [7:0]    rtc_status;
  logic [31:0]   rtc_date_lo;
  logic [31:0]   rtc_date_hi;

  result_t gpio_readback_q[$];

  int n_sent;
  int n_checked;
  int n_sessions;
  int n_cfg_writes;
  int n_errors;
  int src_idle_pct;
  int sink_stall_pct;

  function automatic int data_bytes_of(input logic [2:0] sel);
    case (sel)
      CMD_DATETIME: return int'(DateTimeBytes);
      CMD_STATUS:   return int'(StatusBytes);
      CMD_TIME:     return int'(TimeBytes);
      default:      return 0;
    endcase
  endfunction

  task automatic reset_rtc_model();
    rtc_phase   = PHASE_IDLE;
    rtc_shift   = '0;
    rtc_bit     = '0;
    rtc_cmd     = '0;
    rtc_cmd_on  = 1'b0;
    rtc_left    = '0;
    rtc_status  = StatusRstVal;
    rtc_date_lo = DateLowRstVal;
    rtc_date_hi = DateHighRstVal;
  endtask

  task automatic drop_command();
    rtc_cmd_on = 1'b0;
    rtc_cmd    = '0;
    rtc_left   = '0;
  endtask

  task automatic close_byte();
    if (!rtc_cmd_on) begin
      if (rtc_shift[3:0] == CmdMagic) begin
        rtc_cmd = rtc_shift;
        if (rtc_shift[6:4] == CMD_RESET) rtc_status = 8'h00;
        rtc_left   = 3'(data_bytes_of(rtc_shift[6:4]));
        rtc_cmd_on = (rtc_left != 0);
        if (rtc_left == 0) drop_command();
      end
    end else begin
      if (rtc_left != 0) rtc_left--;
      if (rtc_cmd[6:4] == CMD_STATUS) rtc_status = rtc_shift;
      if (rtc_left == 0) drop_command();
    end
    rtc_shift = '0;
    rtc_bit   = '0;
  endtask

  function automatic logic rtc_read_bit();
    logic [63:0] dw;
    logic [7:0]  b;
    dw = {rtc_date_hi, rtc_date_lo};
    b = 8'h00;
    if (!rtc_cmd_on) return 1'b0;
    case (rtc_cmd[6:4])
      CMD_DATETIME, CMD_TIME: b = dw[8 * (3'd7 - rtc_left) +: 8];
      CMD_STATUS:             b = rtc_status;
      default:                b = 8'h00;
    endcase
    return b[rtc_bit];
  endfunction

  task automatic predict_gpio_write(input logic [3:0] levels, input logic [3:0] dirs,
                                    output result_t r);
    logic [3:0] pins;
    logic [3:0] drv;
    logic       upd;
    pins = levels;
    upd  = 1'b0;
    case (rtc_phase)
      PHASE_IDLE: begin
        if (pins[0] && !pins[2]) rtc_phase = PHASE_CLK;
      end
      PHASE_CLK: begin
        if (pins[0] && pins[2]) rtc_phase = PHASE_XFER;
        else if (!(pins[0] && !pins[2])) rtc_phase = PHASE_IDLE;
      end
      PHASE_XFER: begin
        if (!pins[0]) begin
          rtc_shift[rtc_bit] = pins[1];
        end else if (pins[2]) begin
          if (rtc_cmd[CmdReadIdx]) begin
            drv  = {1'b0, 1'b1, rtc_read_bit(), 1'b1};
            pins = (pins & dirs) | (drv & ~dirs);
            upd  = 1'b1;
            rtc_bit++;
            if (rtc_bit == 0) begin
              if (rtc_left != 0) rtc_left--;
              if (rtc_left == 0) drop_command();
            end
          end else begin
            rtc_bit++;
            if (rtc_bit == 0) close_byte();
          end
        end else begin
          // select dropped with clock high: abort, status survives
          rtc_shift = '0;
          rtc_bit   = '0;
          drop_command();
          rtc_phase = PHASE_CLK;
          pins = (pins & dirs) | (4'b0001 & ~dirs);
          upd  = 1'b1;
        end
      end
      default: rtc_phase = PHASE_IDLE;
    endcase
    r.pins_out     = pins;
    r.pins_updated = upd;
  endtask

  task automatic send_item(input logic [3:0] levels, input logic [3:0] dirs);
    result_t r;
    case (n_sent * 3 / ItemGoal)
      0: begin src_idle_pct = 10; sink_stall_pct = 59; end
      1: begin src_idle_pct = 59; sink_stall_pct = 10; end
      default: begin src_idle_pct = 0; sink_stall_pct = 0; end
    endcase
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid_i       <= 1'b1;
    pin_levels_i     <= levels;
    pin_directions_i <= dirs;
    do @(posedge clk_i); while (in_stall_o);
    predict_gpio_write(levels, dirs, r);
    gpio_readback_q.push_back(r);
    n_sent++;
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
  endtask

  task automatic send_gpio(input logic clk_lvl, input logic dat, input logic sel);
    logic b3;
    b3 = 1'($urandom_range(1));
    send_item({b3, sel, dat, clk_lvl}, 4'($urandom_range(15)));
  endtask

  // start sequence, command plus data bits LSB first, then select drop
  task automatic run_session(input logic [7:0] cmd, input int n_data, input int cut);
    logic b;
    send_gpio(1'b1, 1'($urandom_range(1)), 1'b0);
    send_gpio(1'b1, 1'($urandom_range(1)), 1'b1);
    for (int k = 0; k < 8 * (n_data + 1); k++) begin
      if (k == cut) break;
      b = (k < 8) ? cmd[k] : 1'($urandom_range(1));
      send_gpio(1'b0, b, 1'b1);
      send_gpio(1'b1, 1'($urandom_range(1)), 1'b1);
    end
    send_gpio(1'b1, 1'($urandom_range(1)), 1'b0);
    send_gpio(1'b0, 1'($urandom_range(1)), 1'b0);
    n_sessions++;
  endtask

  task automatic write_date_words(input logic [31:0] lo, input logic [31:0] hi);
    stop_sending();
    while (gpio_readback_q.size() != 0) @(posedge clk_i);
    repeat (ResultLatency) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_DATE_LOW;
    cfg_data_i  <= lo;
    @(posedge clk_i);
    cfg_index_i <= CFG_DATE_HIGH;
    cfg_data_i  <= hi;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rtc_date_lo = lo;
    rtc_date_hi = hi;
    n_cfg_writes += 2;
  endtask

  task automatic test_pin_extremes();
    send_item(4'h0, 4'h0);
    send_item(4'hF, 4'hF);
    send_item(4'hF, 4'h0);
    send_item(4'h0, 4'hF);
    run_session(BadMagicCmd, 0, -1);
  endtask

  task automatic test_command_set();
    // reads first so the status reset value is seen before any reset command
    for (int sel = 7; sel >= 0; sel--)
      run_session({1'b1, 3'(sel), CmdMagic}, data_bytes_of(3'(sel)), -1);
    for (int sel = 0; sel < 8; sel++)
      run_session({1'b0, 3'(sel), CmdMagic}, data_bytes_of(3'(sel)), -1);
    run_session({1'b1, CMD_STATUS, CmdMagic}, int'(StatusBytes), -1);
  endtask

  task automatic test_date_registers();
    write_date_words(32'h0000_0000, 32'h0000_0000);
    run_session({1'b1, CMD_DATETIME, CmdMagic}, int'(DateTimeBytes), -1);
    write_date_words(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_session({1'b1, CMD_DATETIME, CmdMagic}, int'(DateTimeBytes), -1);
    write_date_words($urandom, $urandom);
    run_session({1'b1, CMD_TIME, CmdMagic}, int'(TimeBytes), -1);
  endtask

  task automatic test_random_sessions();
    int         first;
    int         kind;
    int         n;
    int         cut;
    logic       rd;
    logic [2:0] sel;
    logic [7:0] cmd;
    first = n_sent;
    for (int half = 0; half < 2; half++) begin
      write_date_words($urandom, $urandom);
      while (n_sent - first < RandomItems * (half + 1) / 2) begin
        kind = $urandom_range(99);
        if (kind < 10) begin
          repeat ($urandom_range(1, 6))
            send_item(4'($urandom_range(15)), 4'($urandom_range(15)));
        end else begin
          rd  = 1'($urandom_range(1));
          sel = 3'($urandom_range(7));
          if (kind < 20) begin
            cmd = 8'($urandom_range(255));
            n   = $urandom_range(2);
          end else begin
            cmd = {rd, sel, CmdMagic};
            n   = data_bytes_of(sel);
            // an extra byte is taken as a fresh command byte
            if ($urandom_range(3) == 0) n++;
          end
          cut = (kind < 35) ? int'($urandom_range(8 * (n + 1) - 1)) : -1;
          run_session(cmd, n, cut);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin : check_results
    result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_checked++;
      if (gpio_readback_q.size() == 0) begin
        $error("unexpected transaction: pins_out %h pins_updated %b",
               pins_out_o, pins_updated_o);
        n_errors++;
      end else begin
        exp_r = gpio_readback_q.pop_front();
        if (pins_out_o !== exp_r.pins_out) begin
          $error("pins_out: expected %h, actual %h", exp_r.pins_out, pins_out_o);
          n_errors++;
        end
        if (pins_updated_o !== exp_r.pins_updated) begin
          $error("pins_updated: expected %b, actual %b",
                 exp_r.pins_updated, pins_updated_o);
          n_errors++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < sink_stall_pct);
  end

  initial begin
    n_sent = 0;
    n_checked = 0;
    n_sessions = 0;
    n_cfg_writes = 0;
    n_errors = 0;
    src_idle_pct = 10;
    sink_stall_pct = 59;
    reset_rtc_model();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_pin_extremes();
    test_command_set();
    test_date_registers();
    test_random_sessions();
    stop_sending();
    while (gpio_readback_q.size() != 0) @(posedge clk_i);
    repeat (ResultLatency + 2) @(posedge clk_i);
    $display("%0d gpio writes in %0d serial sessions, %0d results compared",
             n_sent, n_sessions, n_checked);
    $display("%0d date register writes, %0d mismatches", n_cfg_writes, n_errors);
    if (n_errors == 0) begin
      $display("PASS serial_rtc_gpio_interface");
    end else begin
      $display("FAIL serial_rtc_gpio_interface");
    end
    $finish;
  end

  initial begin : run_limit
    #3_000_000;
    $display("timeout with %0d results outstanding", gpio_readback_q.size());
    $display("FAIL serial_rtc_gpio_interface");
    $finish;
  end

endmodule

// ===== serial_rtc_gpio_interface.f =====
rtl/core/srtc_pkg.sv
rtl/core/srtc_core.sv
rtl/core/serial_rtc_gpio_interface.sv
dv/serial_rtc_gpio_interface_tb.sv
